// File: rtl/analog_gamepad_serial_responder_top_assert.svh
// Assertion macros used by the gamepad responder core.
`ifndef ANALOG_GAMEPAD_SERIAL_RESPONDER_TOP_ASSERT_SVH
`define ANALOG_GAMEPAD_SERIAL_RESPONDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define AGSR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gamepad responder check failed");

// Next-cycle implication, disabled while reset is active.
`define AGSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gamepad responder check failed");

`endif

// File: rtl/agsr_pkg.sv
// Types and constants for the gamepad serial responder.
package agsr_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_XFER  = 3'd0,
    OP_BTN   = 3'd1,
    OP_AXIS  = 3'd2,
    OP_MODE  = 3'd3,
    OP_RESET = 3'd4
  } agsr_op_e;

  // Transfer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_READY    = 4'd1,
    PH_ID_HIGH  = 4'd2,
    PH_BTN_LOW  = 4'd3,
    PH_BTN_HIGH = 4'd4,
    PH_RX       = 4'd5,
    PH_RY       = 4'd6,
    PH_LX       = 4'd7,
    PH_LY       = 4'd8
  } agsr_phase_e;

  localparam logic [15:0] ID_DIGITAL  = 16'h5A41;
  localparam logic [15:0] ID_ANALOG   = 16'h5A53;
  localparam logic [7:0]  CMD_START   = 8'h01;
  localparam logic [7:0]  CMD_POLL    = 8'h42;
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam logic [7:0]  AXIS_CENTRE = 8'h80;
  localparam logic [15:0] BTN_RELEASED = 16'hFFFF;

  // One registered input word
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_in;
    logic [3:0] button_index;
    logic       pressed;
    logic [1:0] axis_index;
    logic [7:0] axis_value;
  } agsr_req_t;

endpackage

// File: rtl/agsr_in_stage.sv
// Input register stage of the gamepad responder.
module agsr_in_stage
  import agsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  agsr_req_t in_req_i,
  output logic      req_valid_o,
  input  logic      req_take_i,
  output agsr_req_t req_o
);

  logic      valid_q, valid_d;
  agsr_req_t req_q;
  logic      load;

  // Accept a new word whenever the held one is empty or leaving
  assign in_ready_o = !valid_q || req_take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (req_take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= in_req_i;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// File: rtl/agsr_core.sv
// Gamepad state, transfer sequencer and result register.
module agsr_core
  import agsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  agsr_req_t req_i,
  output logic      req_take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [7:0] reply_byte_o,
  output logic      ack_o,
  output logic      analog_on_o
);

  agsr_phase_e phase_q, phase_d;
  logic [15:0] buttons_q, buttons_d;
  logic [7:0]  axis_q [4];
  logic [7:0]  axis_d [4];
  logic        analog_q, analog_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  dout_q, dout_d;
  logic        ack_q, ack_d;
  logic        analog_out_q;
  logic [15:0] cur_id;
  logic [15:0] btn_mask;
  logic        take;

  // Move a word on when the result register is free or being drained
  assign take       = req_valid_i && (!out_valid_q || out_ready_i);
  assign req_take_o = take;

  assign cur_id   = analog_q ? ID_ANALOG : ID_DIGITAL;
  assign btn_mask = 16'(1) << req_i.button_index;

  // Decode one word against the current state
  always_comb begin
    phase_d   = phase_q;
    buttons_d = buttons_q;
    axis_d    = axis_q;
    analog_d  = analog_q;
    dout_d    = IDLE_BYTE;
    ack_d     = 1'b0;
    if (take) begin
      case (req_i.op)
        OP_XFER: begin
          unique case (phase_q)
            PH_IDLE: begin
              if (req_i.data_in == CMD_START) begin
                phase_d = PH_READY;
                ack_d   = 1'b1;
              end
            end
            PH_READY: begin
              if (req_i.data_in == CMD_POLL) begin
                dout_d  = cur_id[7:0];
                phase_d = PH_ID_HIGH;
                ack_d   = 1'b1;
              end
            end
            PH_ID_HIGH: begin
              dout_d  = cur_id[15:8];
              phase_d = PH_BTN_LOW;
              ack_d   = 1'b1;
            end
            PH_BTN_LOW: begin
              dout_d  = buttons_q[7:0];
              phase_d = PH_BTN_HIGH;
              ack_d   = 1'b1;
            end
            PH_BTN_HIGH: begin
              dout_d = buttons_q[15:8];
              if (analog_q) begin
                phase_d = PH_RX;
                ack_d   = 1'b1;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            PH_RX: begin
              dout_d  = axis_q[0];
              phase_d = PH_RY;
              ack_d   = 1'b1;
            end
            PH_RY: begin
              dout_d  = axis_q[1];
              phase_d = PH_LX;
              ack_d   = 1'b1;
            end
            PH_LX: begin
              dout_d  = axis_q[2];
              phase_d = PH_LY;
              ack_d   = 1'b1;
            end
            PH_LY: begin
              dout_d  = axis_q[3];
              phase_d = PH_IDLE;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        OP_BTN: begin
          if (req_i.pressed) begin
            buttons_d = buttons_q & ~btn_mask;
          end else begin
            buttons_d = buttons_q | btn_mask;
          end
        end
        OP_AXIS: axis_d[req_i.axis_index] = req_i.axis_value;
        OP_MODE: begin
          if (req_i.pressed) begin
            analog_d = !analog_q;
          end
        end
        OP_RESET: phase_d = PH_IDLE;
        default: ;
      endcase
    end
  end

  assign out_valid_d = take ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Advance state and valid on reset-cleared registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      buttons_q   <= BTN_RELEASED;
      axis_q      <= '{AXIS_CENTRE, AXIS_CENTRE, AXIS_CENTRE, AXIS_CENTRE};
      analog_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      buttons_q   <= buttons_d;
      axis_q      <= axis_d;
      analog_q    <= analog_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (take) begin
      dout_q       <= dout_d;
      ack_q        <= ack_d;
      analog_out_q <= analog_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_byte_o = dout_q;
  assign ack_o        = ack_q;
  assign analog_on_o  = analog_out_q;

`include "analog_gamepad_serial_responder_top_assert.svh"

  `AGSR_ASSERT_NOW(a_mode_only_by_op, clk_i, rst_ni, analog_q != $past(analog_q), $past(take) && $past(req_i.op) == OP_MODE && $past(req_i.pressed))
  `AGSR_ASSERT_NOW(a_btn_only_by_op, clk_i, rst_ni, buttons_q != $past(buttons_q), $past(take) && $past(req_i.op) == OP_BTN)
  `AGSR_ASSERT_NEXT(a_abort_to_idle, clk_i, rst_ni, take && req_i.op == OP_RESET, phase_q == PH_IDLE)
  `AGSR_ASSERT_NEXT(a_ack_keeps_xfer, clk_i, rst_ni, take && ack_d, phase_q != PH_IDLE)

endmodule

// File: rtl/analog_gamepad_serial_responder_top.sv
// Top level of the gamepad serial responder.
// Device side of a dual-analog gamepad poll. Every input word (byte exchange,
// button update, axis update, mode button press or transfer abort) yields exactly
// one result word: the reply byte, its acknowledge bit and the analog-mode flag
// after the word. A word passes through an input register and a result register:
// its result is presented once the core has moved it from the input register into
// the result register, which a full result register that is not being drained
// delays, and one word per cycle is sustained while the result side is ready.
// Back-pressure on the result side stalls the input only once both registers are full.
module analog_gamepad_serial_responder_top
  import agsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] data_in_i,
  input  logic [3:0] button_index_i,
  input  logic       pressed_i,
  input  logic [1:0] axis_index_i,
  input  logic [7:0] axis_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] reply_byte_o,
  output logic       ack_o,
  output logic       analog_on_o
);

  agsr_req_t in_req;
  agsr_req_t req;
  logic      req_valid;
  logic      req_take;

  // Pack the input word
  assign in_req = '{op: op_i, data_in: data_in_i, button_index: button_index_i,
                    pressed: pressed_i, axis_index: axis_index_i,
                    axis_value: axis_value_i};

  agsr_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_take_i  (req_take),
    .req_o       (req)
  );

  agsr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .req_take_o   (req_take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reply_byte_o (reply_byte_o),
    .ack_o        (ack_o),
    .analog_on_o  (analog_on_o)
  );

endmodule
